@@ src/acfp_pkg.sv @@
// shared types and constants for the ascii command frame parser
// no dependencies; used by every module under src
package acfp_pkg;

	// default frame store depth in bytes
	localparam int STORE_DEPTH_DEF = 32;

	// only positions 0..10 ever take part in a frame compare
	localparam int MATCH_SPAN = 11;

	// classified-transfer queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// frame characters
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_P = 8'h50;

	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_RESET    = 3'd1,
		KIND_TEMP     = 3'd2,
		KIND_LIGHT    = 3'd3,
		KIND_IRRIG    = 3'd4,
		KIND_PROBE    = 3'd5,
		KIND_OVERFLOW = 3'd6
	} kind_t;

	// one classified byte, handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
	} cls_t;

endpackage

@@ src/ascii_command_frame_parser_top.sv @@
// top level of the ascii command frame parser
// depends on acfp_pkg, acfp_front, acfp_queue, acfp_back
//
// channel  | signals                               | direction
// ---------+---------------------------------------+-------------------------
// rx       | rx_valid, rx_stall, rx_byte           | one received byte in
// frame    | frame_valid, frame_stall, result flds | one classified byte out
//
// one byte per clock while rx_stall is low, one result per byte; a result is
// registered after its byte transfer first in the queue, then in the output register
// asynchronous reset clears the store, fill count, light settings and queue
// rx_stall rises only when the two-entry queue is full, i.e. when the output
// register is stalled and the queue has backed up
module ascii_command_frame_parser_top import acfp_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       frame_valid,
	input  logic       frame_stall,
	output logic [2:0] frame_kind,
	output logic [7:0] payload_first,
	output logic [7:0] payload_second,
	output logic [7:0] payload_third,
	output logic       light_mode_changed,
	output logic [7:0] prior_on_hour,
	output logic [7:0] prior_off_hour
);

	// classified transfers between front and back
	logic push;
	cls_t push_data;
	logic q_full;
	logic pop;
	logic q_nonempty;
	cls_t q_head;

	// front: appends the byte, matches the five frames, flags overflow
	acfp_front #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// queue: lets the front keep taking bytes while a result waits
	acfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head_data (q_head)
	);

	// back: keeps light settings in transfer order, holds the result
	acfp_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_nonempty         (q_nonempty),
		.q_head             (q_head),
		.pop                (pop),
		.frame_valid        (frame_valid),
		.frame_stall        (frame_stall),
		.frame_kind         (frame_kind),
		.payload_first      (payload_first),
		.payload_second     (payload_second),
		.payload_third      (payload_third),
		.light_mode_changed (light_mode_changed),
		.prior_on_hour      (prior_on_hour),
		.prior_off_hour     (prior_off_hour)
	);

endmodule

@@ src/acfp_front.sv @@
// front part: frame store, fill count and frame classification
// depends on acfp_pkg
module acfp_front import acfp_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       push,
	output cls_t       push_data
);

	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [CW-1:0] fill_q;
	logic [7:0]    store_q [MATCH_SPAN];
	logic [7:0]    view    [MATCH_SPAN];
	logic          full;
	logic          head;
	cls_t          cls;
	logic          clear;

	assign rx_stall = q_full;
	assign push     = rx_valid && !q_full;
	assign full     = (fill_q == CW'(STORE_DEPTH));

	// store contents as they stand after this byte is appended
	always_comb begin
		for (int i = 0; i < MATCH_SPAN; i++) begin
			view[i] = (!full && fill_q == CW'(i)) ? rx_byte : store_q[i];
		end
	end

	assign head = (view[0] == CH_S) && (view[1] == CH_T) && (view[2] == CH_A);

	always_comb begin
		cls = '{kind: KIND_NONE, p1: 8'd0, p2: 8'd0, p3: 8'd0};
		priority if (head && view[3] == CH_R && view[4] == CH_E &&
				view[5] == CH_N && view[6] == CH_D) begin
			cls.kind = KIND_RESET;
		end else if (head && view[3] == CH_S && view[4] == CH_T &&
				view[7] == CH_E && view[8] == CH_N && view[9] == CH_D) begin
			cls.kind = KIND_TEMP;
			cls.p1   = view[5];
			cls.p2   = view[6];
		end else if (head && view[3] == CH_S && view[4] == CH_L &&
				view[8] == CH_E && view[9] == CH_N && view[10] == CH_D) begin
			cls.kind = KIND_LIGHT;
			cls.p1   = view[5];
			cls.p2   = view[6];
			cls.p3   = view[7];
		end else if (head && view[3] == CH_S && view[4] == CH_I &&
				view[8] == CH_E && view[9] == CH_N && view[10] == CH_D) begin
			cls.kind = KIND_IRRIG;
			cls.p1   = view[5];
			cls.p2   = view[6];
			cls.p3   = view[7];
		end else if (head && view[3] == CH_C && view[4] == CH_P &&
				view[6] == CH_E && view[7] == CH_N && view[8] == CH_D) begin
			cls.kind = KIND_PROBE;
			cls.p1   = view[5];
		end else if (full) begin
			cls.kind = KIND_OVERFLOW;
		end else begin
			cls.kind = KIND_NONE;
		end
	end

	assign clear     = (cls.kind != KIND_NONE);
	assign push_data = cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < MATCH_SPAN; i++) store_q[i] <= 8'd0;
		end else if (push) begin
			if (clear) begin
				fill_q <= '0;
				for (int i = 0; i < MATCH_SPAN; i++) store_q[i] <= 8'd0;
			end else begin
				fill_q <= fill_q + CW'(1);
				for (int i = 0; i < MATCH_SPAN; i++) store_q[i] <= view[i];
			end
		end
	end

endmodule

@@ src/acfp_queue.sv @@
// short fifo of classified transfers between front and back
// depends on acfp_pkg
module acfp_queue import acfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output cls_t head_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cls_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] count_q;

	assign full      = (count_q == NW'(QUEUE_DEPTH));
	assign nonempty  = (count_q != '0);
	assign head_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/acfp_back.sv @@
// back part: kept light settings and the registered result
// depends on acfp_pkg
module acfp_back import acfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  cls_t       q_head,
	output logic       pop,
	output logic       frame_valid,
	input  logic       frame_stall,
	output logic [2:0] frame_kind,
	output logic [7:0] payload_first,
	output logic [7:0] payload_second,
	output logic [7:0] payload_third,
	output logic       light_mode_changed,
	output logic [7:0] prior_on_hour,
	output logic [7:0] prior_off_hour
);

	logic       valid_q;
	logic [2:0] kind_q;
	logic [7:0] p1_q, p2_q, p3_q;
	logic       changed_q;
	logic [7:0] pon_q, poff_q;
	logic [7:0] mode_q, on_q, off_q;
	logic       is_light;

	assign pop      = q_nonempty && (!valid_q || !frame_stall);
	assign is_light = (q_head.kind == KIND_LIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mode_q  <= 8'd0;
			on_q    <= 8'd0;
			off_q   <= 8'd0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (!frame_stall) begin
				valid_q <= 1'b0;
			end
			if (pop && is_light) begin
				mode_q <= q_head.p3;
				on_q   <= q_head.p1;
				off_q  <= q_head.p2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= q_head.kind;
			p1_q      <= q_head.p1;
			p2_q      <= q_head.p2;
			p3_q      <= q_head.p3;
			changed_q <= is_light && (q_head.p3 != mode_q);
			pon_q     <= is_light ? on_q : 8'd0;
			poff_q    <= is_light ? off_q : 8'd0;
		end
	end

	assign frame_valid        = valid_q;
	assign frame_kind         = kind_q;
	assign payload_first      = p1_q;
	assign payload_second     = p2_q;
	assign payload_third      = p3_q;
	assign light_mode_changed = changed_q;
	assign prior_on_hour      = pon_q;
	assign prior_off_hour     = poff_q;

endmodule
